// File: sv/fisp_pkg.sv
// ----------------------------------------------------------------------------
// fisp_pkg
// Types and constants shared by the boot image section parser modules.
// ----------------------------------------------------------------------------
package fisp_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 30;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

  // Record kinds
  localparam logic [KIND_W-1:0] KIND_SECTION = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENTRY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

  // Error codes
  localparam logic [WORD_W-1:0] ERR_SIGNATURE = 32'd0;
  localparam logic [WORD_W-1:0] ERR_SIZES     = 32'd1;
  localparam logic [WORD_W-1:0] ERR_CHECKSUM  = 32'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_HIGH    = 2'd2;

  localparam logic [7:0] SIG_LOW_RESET  = 8'd67;
  localparam logic [7:0] SIG_HIGH_RESET = 8'd89;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_LEN   = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_DATA  = 7'b0001000,
    PH_ENTRY = 7'b0010000,
    PH_CSUM  = 7'b0100000,
    PH_HALT  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] image_words;
    logic [7:0]         sig_low;
    logic [7:0]         sig_high;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] image_word;
    logic              first_word;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] record_kind;
    logic [WORD_W-1:0] target_address;
    logic [WORD_W-1:0] record_value;
  } rec_t;

  function automatic logic [COUNT_W-1:0] dec_sat(input logic [COUNT_W-1:0] x);
    dec_sat = (x != '0) ? x - 1'b1 : '0;
  endfunction

endpackage

// File: sv/fisp_in_stage.sv
// ----------------------------------------------------------------------------
// fisp_in_stage
// Input register: captures one image word and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module fisp_in_stage
  import fisp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  fire,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r;
  item_t item_r;

  // Stall only while a held word cannot move on this cycle.
  assign in_stall = valid_r && !fire;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: sv/fisp_parse.sv
// ----------------------------------------------------------------------------
// fisp_parse
// Parse state and per-word decode: phase, checksum, counters and write
// address, plus the record each word produces.
// ----------------------------------------------------------------------------
module fisp_parse
  import fisp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  s1_valid,
  input  item_t s1_item,
  input  logic  slot_free,
  output logic  fire,
  output logic  emit,
  output rec_t  rec
);

  phase_t              phase_r, phase_nxt;
  logic [WORD_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0]  iwl_r, iwl_nxt;
  logic [COUNT_W-1:0]  swl_r, swl_nxt;
  logic [WORD_W-1:0]   waddr_r, waddr_nxt;

  logic [WORD_W-1:0]   w;
  logic [COUNT_W-1:0]  iwl_dec;
  logic [COUNT_W-1:0]  swl_dec;
  logic                sig_ok;
  logic                too_short;

  assign w         = s1_item.image_word;
  assign iwl_dec   = dec_sat(iwl_r);
  assign swl_dec   = swl_r - 1'b1;
  assign sig_ok    = (w[7:0] == cfg.sig_low) && (w[15:8] == cfg.sig_high);
  assign too_short = {1'b0, iwl_dec} < ({1'b0, swl_r} + (COUNT_W+1)'(2));

  // A word that makes no record never waits on the output register.
  assign fire = s1_valid && (slot_free || !emit);

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    iwl_nxt   = iwl_r;
    swl_nxt   = swl_r;
    waddr_nxt = waddr_r;
    emit      = 1'b0;
    rec       = '{record_kind: KIND_ERROR, target_address: '0, record_value: '0};

    if (s1_item.first_word) begin
      sum_nxt   = '0;
      swl_nxt   = '0;
      waddr_nxt = '0;
      if (!sig_ok) begin
        iwl_nxt   = '0;
        phase_nxt = PH_HALT;
        emit      = 1'b1;
        rec.record_value = ERR_SIGNATURE;
      end else begin
        iwl_nxt   = dec_sat(cfg.image_words);
        phase_nxt = PH_LEN;
      end
    end else begin
      case (phase_r)
        PH_LEN: begin
          iwl_nxt   = iwl_dec;
          swl_nxt   = w[COUNT_W-1:0];
          phase_nxt = (w[COUNT_W-1:0] != '0) ? PH_ADDR : PH_ENTRY;
        end
        PH_ADDR: begin
          emit = 1'b1;
          if (too_short) begin
            iwl_nxt   = iwl_dec;
            phase_nxt = PH_HALT;
            rec.record_value = ERR_SIZES;
          end else begin
            iwl_nxt   = iwl_dec - swl_r;
            waddr_nxt = w;
            phase_nxt = PH_DATA;
            rec.record_kind    = KIND_SECTION;
            rec.target_address = w;
            rec.record_value   = {swl_r, 2'b00};
          end
        end
        PH_DATA: begin
          emit      = 1'b1;
          sum_nxt   = sum_r + w;
          waddr_nxt = waddr_r + WORD_BYTES;
          swl_nxt   = swl_dec;
          if (swl_dec == '0) begin
            phase_nxt = PH_LEN;
          end
          rec.record_kind    = KIND_WRITE;
          rec.target_address = waddr_r;
          rec.record_value   = w;
        end
        PH_ENTRY: begin
          emit      = 1'b1;
          iwl_nxt   = iwl_dec;
          phase_nxt = PH_CSUM;
          rec.record_kind    = KIND_ENTRY;
          rec.target_address = w;
        end
        PH_CSUM: begin
          emit      = 1'b1;
          iwl_nxt   = iwl_dec;
          phase_nxt = PH_HALT;
          if (w != sum_r) begin
            rec.record_value = ERR_CHECKSUM;
          end else begin
            rec.record_kind = KIND_DONE;
          end
        end
        default: begin
          // idle or halted: drop stray words
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= '0;
      iwl_r   <= '0;
      swl_r   <= '0;
      waddr_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      iwl_r   <= iwl_nxt;
      swl_r   <= swl_nxt;
      waddr_r <= waddr_nxt;
    end
  end

endmodule

// File: sv/fisp_out_stage.sv
// ----------------------------------------------------------------------------
// fisp_out_stage
// Output register: holds one record until the downstream side takes it.
// ----------------------------------------------------------------------------
module fisp_out_stage
  import fisp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  rec_t rec,
  input  logic out_stall,
  output logic slot_free,
  output logic out_valid,
  output rec_t out_rec
);

  logic valid_r;
  rec_t rec_r;

  assign slot_free = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_rec   = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      rec_r <= rec;
    end
  end

endmodule

// File: sv/firmware_image_section_parser_core.sv
// ----------------------------------------------------------------------------
// firmware_image_section_parser_core
// Boot image section parser: checks the signature word, walks the section
// headers, emits section and write records, checks the closing checksum.
//
//   port group  direction  contents
//   in_*        input      image_word (32), first_word (1); valid / stall
//   out_*       output     record_kind (3), target_address, record_value;
//                          valid / stall
//   cfg_*       input      write enable, 2-bit register index, 30-bit data
//
// One word per cycle sustained while the output does not stall. A word's
// record shows on out_valid after the input register, then the result
// register. The per-word decode (adds, compares, counter updates) sits
// between the two registers. Reset is synchronous on rst_n and clears the
// parse state and both valid flags. A stalled output holds its record; the
// input keeps flowing until the held word needs the output slot.
// ----------------------------------------------------------------------------
module firmware_image_section_parser_core
  import fisp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    in_image_word,
  input  logic                 in_first_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    out_record_kind,
  output logic [WORD_W-1:0]    out_target_address,
  output logic [WORD_W-1:0]    out_record_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_wdata
);

  cfg_t  cfg_r;
  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  fire;
  logic  emit;
  logic  slot_free;
  rec_t  rec;
  rec_t  out_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_words <= '0;
      cfg_r.sig_low     <= SIG_LOW_RESET;
      cfg_r.sig_high    <= SIG_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WORDS: cfg_r.image_words <= cfg_wdata;
        REG_SIG_LOW:     cfg_r.sig_low     <= cfg_wdata[7:0];
        REG_SIG_HIGH:    cfg_r.sig_high    <= cfg_wdata[7:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  assign in_item = '{image_word: in_image_word, first_word: in_first_word};

  fisp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fire     (fire),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  fisp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .slot_free (slot_free),
    .fire      (fire),
    .emit      (emit),
    .rec       (rec)
  );

  fisp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .rec       (rec),
    .out_stall (out_stall),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  assign out_record_kind    = out_rec.record_kind;
  assign out_target_address = out_rec.target_address;
  assign out_record_value   = out_rec.record_value;

  // A held word that makes a record only advances into a free slot.
  a_fire_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit) |-> slot_free)
    else $error("record loaded into an occupied output register");

  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && !slot_free && emit))
    else $error("input stalled without a blocked word");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_record_kind <= KIND_ERROR))
    else $error("record kind out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// File: verif/firmware_image_section_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// firmware_image_section_parser_core_tb
// Streams boot images into the section parser and checks every record it
// returns against a cycle-free model of the parse, held in this file. A short
// directed run hits the signature, size, checksum, restart and wrap cases;
// random images follow under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module firmware_image_section_parser_core_tb;
  import fisp_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_image_word = '0;
  logic                 in_first_word = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    out_record_kind;
  logic [WORD_W-1:0]    out_target_address;
  logic [WORD_W-1:0]    out_record_value;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;

  firmware_image_section_parser_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_image_word      (in_image_word),
    .in_first_word      (in_first_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_target_address (out_target_address),
    .out_record_value   (out_record_value),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #1 clk = ~clk;

  item_t pending_words[$];
  rec_t  expected_recs[$];
  int    fail_count = 0;
  int    items_made = 0;
  int    send_idle = 0;
  int    recv_stall = 0;

  // Register copies
  logic [COUNT_W-1:0] cfg_image_words = '0;
  logic [7:0]         cfg_sig_low  = SIG_LOW_RESET;
  logic [7:0]         cfg_sig_high = SIG_HIGH_RESET;

  // Parse state of the model
  phase_t             parse_state = PH_IDLE;
  logic [WORD_W-1:0]  sum_so_far = '0;
  logic [COUNT_W-1:0] words_left = '0;
  logic [COUNT_W-1:0] section_left = '0;
  logic [WORD_W-1:0]  write_addr = '0;

  function automatic void take_word();
    if (words_left != '0) words_left = words_left - 1'b1;
  endfunction

  // Advance the parse by one word; returns 1 when the word yields a record.
  function automatic bit parse_word(input logic [WORD_W-1:0] w, input logic first,
                                    output rec_t rec);
    rec = '0;
    if (first) begin
      sum_so_far = '0;
      section_left = '0;
      write_addr = '0;
      if (w[7:0] != cfg_sig_low || w[15:8] != cfg_sig_high) begin
        words_left = '0;
        parse_state = PH_HALT;
        rec.record_kind = KIND_ERROR;
        rec.record_value = ERR_SIGNATURE;
        return 1'b1;
      end
      words_left = cfg_image_words;
      take_word();
      parse_state = PH_LEN;
      return 1'b0;
    end
    case (parse_state)
      PH_LEN: begin
        take_word();
        section_left = w[COUNT_W-1:0];
        if (section_left != '0) parse_state = PH_ADDR;
        else parse_state = PH_ENTRY;
        return 1'b0;
      end
      PH_ADDR: begin
        take_word();
        if ({2'b00, words_left} < {2'b00, section_left} + 32'd2) begin
          parse_state = PH_HALT;
          rec.record_kind = KIND_ERROR;
          rec.record_value = ERR_SIZES;
          return 1'b1;
        end
        words_left = words_left - section_left;
        write_addr = w;
        parse_state = PH_DATA;
        rec.record_kind = KIND_SECTION;
        rec.target_address = w;
        rec.record_value = {section_left, 2'b00};
        return 1'b1;
      end
      PH_DATA: begin
        rec.record_kind = KIND_WRITE;
        rec.target_address = write_addr;
        rec.record_value = w;
        sum_so_far = sum_so_far + w;
        write_addr = write_addr + WORD_BYTES;
        section_left = section_left - 1'b1;
        if (section_left == '0) parse_state = PH_LEN;
        return 1'b1;
      end
      PH_ENTRY: begin
        take_word();
        parse_state = PH_CSUM;
        rec.record_kind = KIND_ENTRY;
        rec.target_address = w;
        return 1'b1;
      end
      PH_CSUM: begin
        take_word();
        parse_state = PH_HALT;
        if (w != sum_so_far) begin
          rec.record_kind = KIND_ERROR;
          rec.record_value = ERR_CHECKSUM;
        end else begin
          rec.record_kind = KIND_DONE;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Word driver: hold a word until it is taken, predict it on acceptance.
  always @(posedge clk) begin : drive_words
    rec_t  rec;
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_word(in_image_word, in_first_word, rec))
          expected_recs = {expected_recs, rec};
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = pending_words.pop_front();
          in_valid      <= 1'b1;
          in_image_word <= nxt.image_word;
          in_first_word <= nxt.first_word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Record monitor
  always @(posedge clk) begin : check_records
    rec_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
      if (out_valid && !out_stall) begin
        if (expected_recs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected record: kind %0d addr %h value %h",
                     out_record_kind, out_target_address, out_record_value);
        end else begin
          want = expected_recs.pop_front();
          if (out_record_kind !== want.record_kind ||
              out_target_address !== want.target_address ||
              out_record_value !== want.record_value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("record mismatch: expected kind %0d addr %h value %h, got %0d %h %h",
                       want.record_kind, want.target_address, want.record_value,
                       out_record_kind, out_target_address, out_record_value);
          end
        end
      end
    end
  end

  task automatic push_word(input logic [WORD_W-1:0] w, input logic first);
    item_t word;
    word.image_word = w;
    word.first_word = first;
    pending_words = {pending_words, word};
    items_made++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WORDS: cfg_image_words = data;
      REG_SIG_LOW:     cfg_sig_low = data[7:0];
      REG_SIG_HIGH:    cfg_sig_high = data[7:0];
      default: ;
    endcase
  endtask

  // Wait until every word is taken and every record is back, then let the
  // pipeline settle in case the last word gave no record.
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_recs.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // One image, mostly well formed; now and then a bad signature, a cut-off
  // image or a wild length word.
  task automatic gen_image();
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] sum;
    int nsec;
    int len;
    sum = '0;
    w = $urandom;
    if ($urandom_range(99) < 8) begin
      if (w[15:0] == {cfg_sig_high, cfg_sig_low}) w[w[3:0]] = ~w[w[3:0]];
      if (w[15:0] == {cfg_sig_high, cfg_sig_low}) w[0] = ~w[0];
      push_word(w, 1'b1);
      repeat ($urandom_range(2)) push_word($urandom, 1'b0);
      return;
    end
    w[15:0] = {cfg_sig_high, cfg_sig_low};
    push_word(w, 1'b1);
    nsec = $urandom_range(3);
    for (int i = 0; i < nsec; i++) begin
      if ($urandom_range(99) < 4) return;
      if ($urandom_range(99) < 4) begin
        push_word($urandom, 1'b0);
        push_word($urandom, 1'b0);
        repeat ($urandom_range(4, 1)) push_word($urandom, 1'b0);
        return;
      end
      len = $urandom_range(6, 1);
      w = $urandom;
      w[COUNT_W-1:0] = COUNT_W'(len);
      push_word(w, 1'b0);
      push_word($urandom, 1'b0);
      repeat (len) begin
        w = $urandom;
        sum = sum + w;
        push_word(w, 1'b0);
      end
    end
    w = $urandom;
    w[COUNT_W-1:0] = '0;
    push_word(w, 1'b0);
    push_word($urandom, 1'b0);
    if ($urandom_range(99) < 20) push_word($urandom, 1'b0);
    else push_word(sum, 1'b0);
    if ($urandom_range(99) < 20) push_word($urandom, 1'b0);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] iw, input logic [7:0] sig_lo,
                           input logic [7:0] sig_hi, input int mode, input int n);
    int start;
    write_reg(REG_IMAGE_WORDS, iw);
    write_reg(REG_SIG_LOW, {22'($urandom), sig_lo});
    write_reg(REG_SIG_HIGH, {22'($urandom), sig_hi});
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 59; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 59; end
      default: begin send_idle = 22; recv_stall = 22; end
    endcase
    start = items_made;
    while (items_made - start < n) gen_image();
    drain();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no image length, default signature
    push_word(32'hFFFF_FFFF, 1'b0);   // stray word while idle
    push_word(32'h0000_5942, 1'b1);   // low signature byte wrong
    push_word(32'h0000_0043, 1'b1);   // high signature byte wrong
    push_word(32'h0000_0000, 1'b0);   // stray word while halted
    push_word(32'hABCD_5943, 1'b1);
    push_word(32'hC000_0000, 1'b0);   // length bits zero, top bits ignored
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0000_0000, 1'b0);   // checksum matches
    push_word(32'h0000_5943, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h1234_5678, 1'b0);   // section does not fit
    drain();

    write_reg(REG_IMAGE_WORDS, 30'd10);
    push_word(32'hFFFF_5943, 1'b1);
    push_word(32'h0000_0005, 1'b0);   // leaves exactly two words
    push_word(32'h8000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h0001_5943, 1'b1);   // restart in the middle of data
    push_word(32'h0000_0005, 1'b0);
    push_word(32'hFFFF_FFF8, 1'b0);   // write address wraps
    for (int i = 1; i <= 5; i++) push_word(i, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0000_0100, 1'b0);
    push_word(32'h0000_0010, 1'b0);   // checksum off by one
    drain();

    run_phase(30'h3FFF_FFFF, 8'h00, 8'h00, 0, 46);
    run_phase(30'd40, 8'hFF, 8'hFF, 1, 46);
    run_phase(30'($urandom_range(40, 16)), 8'($urandom), 8'($urandom), 2, 46);
    run_phase(30'h3FFF_FFFF, 8'($urandom), 8'($urandom), 3, 46);
    run_phase(30'd0, 8'($urandom), 8'($urandom), 0, 46);
    run_phase(30'($urandom_range(60, 20)), 8'hFF, 8'h00, 1, 46);
    run_phase(30'h3FFF_FFFF, 8'h00, 8'hFF, 2, 46);
    run_phase(30'($urandom), 8'($urandom), 8'($urandom), 3, 46);

    send_idle = 0;
    recv_stall = 0;
    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
